>>> sv/brmw_pkg.sv
package brmw_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int BLOCK_COUNT = 8;
    localparam int STORE_SIZE  = BLOCK_BYTES * BLOCK_COUNT;

    // fixed field widths
    localparam int ADDR_W  = 15;
    localparam int DATA_W  = 8;
    localparam int TOUCH_W = 4;
    localparam int CNT_W   = 32;

    // derived widths
    localparam int STORE_AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int POS_RAW  = $clog2(STORE_SIZE + 1);
    localparam int POS_W    = (POS_RAW > ADDR_W) ? POS_RAW : ADDR_W + 1;
    localparam int OFFS_W   = $clog2(BLOCK_BYTES);
    localparam int BLK_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int COV_W    = $clog2(BLOCK_BYTES + 1);

    localparam logic [TOUCH_W-1:0] TOUCH_MAX = '1;

    // request and result codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_READ   = 1'b1;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // response queue
    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic                result_kind;
        logic [DATA_W-1:0]   read_data;
        logic [TOUCH_W-1:0]  touched_blocks;
        logic [CNT_W-1:0]    total_block_reads;
        logic [CNT_W-1:0]    total_block_writes;
        logic                out_of_range;
    } t_rsp;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [DATA_W-1:0]   data;
    } t_mem_wr;

    // accounting stage towards the read data merge
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic                rd_ok;
        logic [TOUCH_W-1:0]  touched;
        logic [CNT_W-1:0]    reads;
        logic [CNT_W-1:0]    writes;
        logic                oor;
    } t_stage;

endpackage

>>> sv/brmw_req_if.sv
interface brmw_req_if
    import brmw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic              start_req;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (
        output valid, req_type, start_req, byte_address, data_byte, last,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_req, byte_address, data_byte, last,
        output ready
    );
endinterface

>>> sv/brmw_rsp_if.sv
interface brmw_rsp_if
    import brmw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [DATA_W-1:0]  read_data;
    logic [TOUCH_W-1:0] touched_blocks;
    logic [CNT_W-1:0]   total_block_reads;
    logic [CNT_W-1:0]   total_block_writes;
    logic               out_of_range;

    modport source (
        output valid, result_kind, read_data, touched_blocks,
               total_block_reads, total_block_writes, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, result_kind, read_data, touched_blocks,
               total_block_reads, total_block_writes, out_of_range,
        output ready
    );
endinterface

>>> sv/block_read_modify_write_engine_unit.sv
// Byte-range write engine over a 32 KiB store of eight 4 KiB blocks, with
// block read/write accounting. One request word is taken per cycle, writes
// and reads in any mix; a write report appears on the word flagged last and
// a read returns one stored byte from the registered read port. Stored bytes
// live in a single byte-wide memory with one write and one registered read
// port; every in-range write word stores its byte at acceptance, so a later
// read always sees it. Results pass through a three-word queue, and outside
// the reset sweep the request side only stalls when that queue, counting the
// word still on its way in, is full. After reset the store is zeroed by a
// sweep over all 32768 bytes during which no request is taken.
module block_read_modify_write_engine_unit
    import brmw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    brmw_req_if.sink   i_req,
    brmw_rsp_if.source o_rsp
);

    logic              accept;
    logic              clr_busy;
    logic              room;
    logic [DATA_W-1:0] rd_data;
    t_mem_wr           mem_wr;
    t_stage            stage;
    t_rsp              push_word;
    t_rsp              head;

    assign i_req.ready = !clr_busy && room;
    assign accept      = i_req.valid && i_req.ready;

    brmw_acct u_acct (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req.req_type),
        .i_start_req    (i_req.start_req),
        .i_byte_address (i_req.byte_address),
        .i_data_byte    (i_req.data_byte),
        .i_last         (i_req.last),
        .o_wr           (mem_wr),
        .o_stage        (stage)
    );

    brmw_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (mem_wr),
        .i_rd_en    (accept && (i_req.req_type == REQ_READ)),
        .i_rd_addr  (STORE_AW'(i_req.byte_address)),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

    always_comb begin
        push_word.result_kind        = stage.kind;
        push_word.read_data          = stage.rd_ok ? rd_data : '0;
        push_word.touched_blocks     = stage.touched;
        push_word.total_block_reads  = stage.reads;
        push_word.total_block_writes = stage.writes;
        push_word.out_of_range       = stage.oor;
    end

    brmw_rsp_q u_rsp_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (stage.valid),
        .i_data    (push_word),
        .i_pending (stage.valid),
        .o_room    (room),
        .o_valid   (o_rsp.valid),
        .o_data    (head),
        .i_ready   (o_rsp.ready)
    );

    assign o_rsp.result_kind        = head.result_kind;
    assign o_rsp.read_data          = head.read_data;
    assign o_rsp.touched_blocks     = head.touched_blocks;
    assign o_rsp.total_block_reads  = head.total_block_reads;
    assign o_rsp.total_block_writes = head.total_block_writes;
    assign o_rsp.out_of_range       = head.out_of_range;

endmodule

>>> sv/brmw_store.sv
module brmw_store
    import brmw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_wr             i_wr,
    input  logic                i_rd_en,
    input  logic [STORE_AW-1:0] i_rd_addr,
    output logic [DATA_W-1:0]   o_rd_data,
    output logic                o_clr_busy
);

    logic [DATA_W-1:0]   r_mem [STORE_SIZE];
    logic [DATA_W-1:0]   r_rd_data;
    logic                r_clr_busy;
    logic [STORE_AW-1:0] r_clr_addr;

    // zeroing sweep after reset, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == STORE_AW'(STORE_SIZE - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

>>> sv/brmw_acct.sv
module brmw_acct
    import brmw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic              i_start_req,
    input  logic [ADDR_W-1:0] i_byte_address,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_last,
    output t_mem_wr           o_wr,
    output t_stage            o_stage
);

    logic [POS_W-1:0]   r_pos;
    logic [BLK_W-1:0]   r_cur;
    logic [COV_W-1:0]   r_cov;
    logic [TOUCH_W-1:0] r_blocks;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_reads;
    logic [CNT_W-1:0]   r_writes;
    t_stage             r_stage;

    logic               w_acc;
    logic               is_read;
    logic [COV_W-1:0]   cov0;
    logic [COV_W-1:0]   cov1;
    logic [POS_W-1:0]   pos0;
    logic [POS_W-1:0]   pos1;
    logic [TOUCH_W-1:0] blocks0;
    logic [TOUCH_W-1:0] blocks1;
    logic               ovf1;
    logic               in_rng;
    logic [BLK_W-1:0]   blk;
    logic               new_blk;
    logic               close_a;
    logic               read_a;
    logic               close_b;
    logic               read_b;
    logic [CNT_W-1:0]   n_reads;
    logic [CNT_W-1:0]   n_writes;
    logic               rd_ok;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    assign is_read = (i_req_type == REQ_READ);
    assign w_acc   = i_accept && !is_read;

    always_comb begin
        cov0    = i_start_req ? '0 : r_cov;
        blocks0 = i_start_req ? '0 : r_blocks;
        pos0    = i_start_req ? POS_W'(i_byte_address) : r_pos;
        in_rng  = (pos0 < POS_W'(STORE_SIZE));
        blk     = BLK_W'(pos0 >> OFFS_W);

        // a start closes the open block; so does leaving it for another one
        close_a = (r_cov != '0) && (i_start_req || (in_rng && (blk != r_cur)));
        read_a  = close_a && (r_cov != COV_W'(BLOCK_BYTES));

        new_blk = in_rng && ((cov0 == '0) || (blk != r_cur));
        blocks1 = (new_blk && (blocks0 != TOUCH_MAX)) ? blocks0 + 1'b1 : blocks0;
        if (!in_rng) begin
            cov1 = cov0;
        end else if (new_blk) begin
            cov1 = COV_W'(1);
        end else begin
            cov1 = cov0 + 1'b1;
        end
        pos1 = in_rng ? pos0 + 1'b1 : POS_W'(STORE_SIZE);
        ovf1 = (!i_start_req && r_ovf) || !in_rng;

        close_b = i_last && (cov1 != '0);
        read_b  = close_b && (cov1 != COV_W'(BLOCK_BYTES));

        n_reads  = sat_add(r_reads, {1'b0, read_a} + {1'b0, read_b});
        n_writes = sat_add(r_writes, {1'b0, close_a} + {1'b0, close_b});

        rd_ok = ({1'b0, i_byte_address} < (ADDR_W + 1)'(STORE_SIZE));
    end

    always_comb begin
        o_wr.en   = w_acc && in_rng;
        o_wr.addr = STORE_AW'(pos0);
        o_wr.data = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cur    <= '0;
            r_cov    <= '0;
            r_blocks <= '0;
            r_ovf    <= 1'b0;
            r_reads  <= '0;
            r_writes <= '0;
        end else if (w_acc) begin
            r_pos    <= pos1;
            if (new_blk) begin
                r_cur <= blk;
            end
            r_cov    <= i_last ? '0 : cov1;
            r_blocks <= i_last ? '0 : blocks1;
            r_ovf    <= i_last ? 1'b0 : ovf1;
            r_reads  <= n_reads;
            r_writes <= n_writes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_accept && (is_read || i_last);
        end
        if (i_accept) begin
            r_stage.kind    <= is_read ? KIND_READ : KIND_WRITE;
            r_stage.rd_ok   <= is_read && rd_ok;
            r_stage.touched <= is_read ? '0 : blocks1;
            r_stage.reads   <= is_read ? r_reads : n_reads;
            r_stage.writes  <= is_read ? r_writes : n_writes;
            r_stage.oor     <= !is_read && ovf1;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> sv/brmw_rsp_q.sv
module brmw_rsp_q
    import brmw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rsp i_data,
    input  logic i_pending,
    output logic o_room,
    output logic o_valid,
    output t_rsp o_data,
    input  logic i_ready
);

    t_rsp               r_ent [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               pop;
    logic [Q_CNT_W:0]   used;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_ent[r_rp];

    // the word in flight from the accounting stage already has a slot booked
    assign used   = {1'b0, r_cnt} + (Q_CNT_W + 1)'(i_pending);
    assign o_room = (used < (Q_CNT_W + 1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
